// ===== src/jch_pkg.sv =====
// ----------------------------------------------------------------------------
// jch_pkg
// Shared constants, codes and controller/datapath interface types for the
// joint category histogram.
// ----------------------------------------------------------------------------
package jch_pkg;

    localparam int BIN_DEPTH      = 4096;
    localparam int MAX_LAYERS     = 4;
    localparam int COUNT_BITS     = 20;

    localparam int ADDR_BITS      = $clog2(BIN_DEPTH);
    localparam int LAYER_IDX_BITS = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CAT_BITS       = 8;
    localparam int RADIX_BITS     = 9;
    localparam int LAYER_BITS     = 3;
    localparam int MASK_BITS      = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PROD_BITS      = ADDR_BITS + RADIX_BITS;
    localparam int SUM_BITS       = PROD_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;
    localparam logic [LAYER_BITS-1:0] LAYER_RESET  = LAYER_BITS'(1);
    localparam logic [RADIX_BITS-1:0] RADIX_RESET  = RADIX_BITS'(16);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAYER_COUNT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX0      = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX1      = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX2      = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIX3      = CFG_INDEX_BITS'(4);

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_END   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fetch;
        logic finish;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic steps_left;
        logic needs_mem;
        logic clear_last;
    } stat_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (v == COUNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== src/jch_ctrl.sv =====
// ----------------------------------------------------------------------------
// jch_ctrl
// Sequencer: clearing pass after reset, word accept, mixed-radix index
// steps, bin fetch and read-modify-write.
// ----------------------------------------------------------------------------
module jch_ctrl
    import jch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] operation,
    input  stat_t      stat,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start && (op_t'(operation) != OP_NONE))
                begin
                    cmd.load   = 1'b1;
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                if (stat.steps_left)
                begin
                    cmd.step = 1'b1;
                end
                else if (stat.needs_mem)
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_UPDATE;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_update_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> $past(cmd.fetch))
        else $error("update without a preceding bin fetch");

endmodule

// ===== src/jch_datapath.sv =====
// ----------------------------------------------------------------------------
// jch_datapath
// Configuration registers, operand registers, mixed-radix index unit,
// histogram bin memory, pixel counters and result registers.
// ----------------------------------------------------------------------------
module jch_datapath
    import jch_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [RADIX_BITS-1:0]     cfg_data,
    input  logic [1:0]                operation,
    input  logic [CAT_BITS-1:0]       category0,
    input  logic [CAT_BITS-1:0]       category1,
    input  logic [CAT_BITS-1:0]       category2,
    input  logic [CAT_BITS-1:0]       category3,
    input  logic [MASK_BITS-1:0]      null_mask,
    input  logic [ADDR_BITS-1:0]      bin_address,
    output logic                      done,
    output logic [1:0]                status,
    output logic [ADDR_BITS-1:0]      bin_index,
    output logic [COUNT_BITS-1:0]     bin_count,
    output logic                      enough_valid,
    output logic [COUNT_BITS-1:0]     valid_pixels,
    output logic [COUNT_BITS-1:0]     total_pixels
);

    logic [LAYER_BITS-1:0]     layer_count_reg;
    logic [RADIX_BITS-1:0]     radix_reg [MAX_LAYERS];
    logic [COUNT_BITS-1:0]     valid_reg;
    logic [COUNT_BITS-1:0]     total_reg;
    logic [ADDR_BITS-1:0]      clr_addr_reg;
    logic                      done_reg;

    op_t                       op_reg;
    logic [CAT_BITS-1:0]       cat_reg [MAX_LAYERS];
    logic [ADDR_BITS-1:0]      addr_reg;
    logic [ADDR_BITS-1:0]      idx_reg;
    logic                      ovf_reg;
    logic                      null_reg;
    logic                      bad_reg;
    logic [LAYER_IDX_BITS-1:0] step_reg;
    logic [COUNT_BITS-1:0]     rd_data_reg;

    status_t                   status_reg;
    logic [ADDR_BITS-1:0]      bin_index_reg;
    logic [COUNT_BITS-1:0]     bin_count_reg;
    logic                      enough_reg;
    logic [COUNT_BITS-1:0]     valid_out_reg;
    logic [COUNT_BITS-1:0]     total_out_reg;

    logic [COUNT_BITS-1:0]     mem [BIN_DEPTH];

    logic [CAT_BITS-1:0]       cat_in [MAX_LAYERS];
    logic [LAYER_IDX_BITS-1:0] layer_last;
    logic                      load_null;
    logic                      load_bad;
    logic                      load_ovf;
    logic [PROD_BITS-1:0]      prod;
    logic [SUM_BITS-1:0]       sum;
    logic                      addr_oob;
    logic                      needs_mem;
    logic [ADDR_BITS-1:0]      mem_addr;
    status_t                   status_next;
    logic [ADDR_BITS-1:0]      index_next;
    logic [COUNT_BITS-1:0]     count_next;
    logic [COUNT_BITS-1:0]     valid_next;
    logic [COUNT_BITS-1:0]     total_next;
    logic [COUNT_BITS-1:0]     wr_data;
    logic                      enough_next;

    assign cat_in[0] = category0;
    assign cat_in[1] = category1;
    assign cat_in[2] = category2;
    assign cat_in[3] = category3;

    always_comb
    begin
        if (layer_count_reg == '0)
        begin
            layer_last = '0;
        end
        else if (32'(layer_count_reg) > MAX_LAYERS)
        begin
            layer_last = LAYER_IDX_BITS'(MAX_LAYERS - 1);
        end
        else
        begin
            layer_last = LAYER_IDX_BITS'(layer_count_reg - 1'b1);
        end
        load_null = 1'b0;
        load_bad  = 1'b0;
        for (int k = 0; k < MAX_LAYERS; k++)
        begin
            if (LAYER_IDX_BITS'(k) <= layer_last)
            begin
                load_null = load_null | null_mask[k];
                if (RADIX_BITS'(cat_in[k]) >= radix_reg[k])
                begin
                    load_bad = 1'b1;
                end
            end
        end
        load_ovf = (32'(category0) >= BIN_DEPTH);
    end

    assign prod      = PROD_BITS'(idx_reg) * PROD_BITS'(radix_reg[step_reg]);
    assign sum       = SUM_BITS'(prod) + SUM_BITS'(cat_reg[step_reg]);
    assign addr_oob  = (32'(addr_reg) >= BIN_DEPTH);
    assign needs_mem = ((op_reg == OP_ACCUM) && !null_reg && !bad_reg && !ovf_reg)
                    || ((op_reg == OP_READ) && !addr_oob);
    assign mem_addr  = (op_reg == OP_READ) ? addr_reg : idx_reg;

    assign stat.steps_left = (step_reg != '0);
    assign stat.needs_mem  = needs_mem;
    assign stat.clear_last = (clr_addr_reg == ADDR_BITS'(BIN_DEPTH - 1));

    always_comb
    begin
        status_next = ST_OK;
        index_next  = '0;
        count_next  = '0;
        valid_next  = valid_reg;
        total_next  = total_reg;
        wr_data     = '0;
        case (op_reg)
            OP_ACCUM:
            begin
                total_next = sat_inc(total_reg);
                if (null_reg)
                begin
                    status_next = ST_NULL;
                end
                else if (bad_reg || ovf_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    valid_next = sat_inc(valid_reg);
                    index_next = idx_reg;
                    if (rd_data_reg == COUNT_MAX)
                    begin
                        status_next = ST_OVERFLOW;
                        count_next  = COUNT_MAX;
                        wr_data     = COUNT_MAX;
                    end
                    else
                    begin
                        count_next = rd_data_reg + 1'b1;
                        wr_data    = rd_data_reg + 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                index_next = addr_reg;
                if (addr_oob)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    count_next = rd_data_reg;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        enough_next = ({valid_next, 1'b0} >= {1'b0, total_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= LAYER_RESET;
            for (int k = 0; k < MAX_LAYERS; k++)
            begin
                radix_reg[k] <= RADIX_RESET;
            end
            valid_reg    <= '0;
            total_reg    <= '0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LAYER_COUNT: layer_count_reg <= cfg_data[LAYER_BITS-1:0];
                    CFG_RADIX0:      radix_reg[0]    <= cfg_data;
                    CFG_RADIX1:      radix_reg[1]    <= cfg_data;
                    CFG_RADIX2:      radix_reg[2]    <= cfg_data;
                    CFG_RADIX3:      radix_reg[3]    <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                if (op_reg == OP_END)
                begin
                    valid_reg <= '0;
                    total_reg <= '0;
                end
                else
                begin
                    valid_reg <= valid_next;
                    total_reg <= total_next;
                end
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(operation);
            addr_reg <= bin_address;
            for (int k = 0; k < MAX_LAYERS; k++)
            begin
                cat_reg[k] <= cat_in[k];
            end
            idx_reg  <= ADDR_BITS'(category0);
            ovf_reg  <= load_ovf;
            null_reg <= load_null;
            bad_reg  <= load_bad;
            step_reg <= (op_t'(operation) == OP_ACCUM) ? layer_last : '0;
        end
        else if (cmd.step)
        begin
            idx_reg  <= sum[ADDR_BITS-1:0];
            ovf_reg  <= ovf_reg | (32'(sum) >= BIN_DEPTH);
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.finish)
        begin
            status_reg    <= status_next;
            bin_index_reg <= index_next;
            bin_count_reg <= count_next;
            enough_reg    <= enough_next;
            valid_out_reg <= valid_next;
            total_out_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.finish && needs_mem)
        begin
            mem[mem_addr] <= wr_data;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign bin_index    = bin_index_reg;
    assign bin_count    = bin_count_reg;
    assign enough_valid = enough_reg;
    assign valid_pixels = valid_out_reg;
    assign total_pixels = total_out_reg;

    a_valid_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg <= total_reg)
        else $error("valid pixel count exceeds total");

    a_skip_no_bin: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == ST_NULL || status_reg == ST_RANGE)
        |-> (bin_count_reg == '0))
        else $error("skipped pixel reports a bin count");

    a_overflow_max: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == ST_OVERFLOW) |-> (bin_count_reg == COUNT_MAX))
        else $error("overflow status without a saturated bin");

endmodule

// ===== src/joint_category_histogram.sv =====
// ----------------------------------------------------------------------------
// joint_category_histogram
// Joint histogram over up to four category layers, mixed-radix bin index,
// read-and-clear bins and per-window valid/total pixel counts.
// ----------------------------------------------------------------------------
// Sequence from accept to done: a counted pixel takes one multiply-add step
// per layer after the first, then a bin fetch and update; a skipped pixel
// takes the steps but no fetch; a read fetches its bin; end takes neither.
// Throughput: one word at a time; busy falls as done rises, so the next word
// may start in that cycle. The result strobe lasts one cycle.
// Reset: clearing pass over the bin memory with busy high; configuration writes are taken throughout.
module joint_category_histogram
    import jch_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                operation,
    input  logic [CAT_BITS-1:0]       category0,
    input  logic [CAT_BITS-1:0]       category1,
    input  logic [CAT_BITS-1:0]       category2,
    input  logic [CAT_BITS-1:0]       category3,
    input  logic [MASK_BITS-1:0]      null_mask,
    input  logic [ADDR_BITS-1:0]      bin_address,
    output logic                      done,
    output logic [1:0]                status,
    output logic [ADDR_BITS-1:0]      bin_index,
    output logic [COUNT_BITS-1:0]     bin_count,
    output logic                      enough_valid,
    output logic [COUNT_BITS-1:0]     valid_pixels,
    output logic [COUNT_BITS-1:0]     total_pixels,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [RADIX_BITS-1:0]     cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    jch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    jch_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .category0    (category0),
        .category1    (category1),
        .category2    (category2),
        .category3    (category3),
        .null_mask    (null_mask),
        .bin_address  (bin_address),
        .done         (done),
        .status       (status),
        .bin_index    (bin_index),
        .bin_count    (bin_count),
        .enough_valid (enough_valid),
        .valid_pixels (valid_pixels),
        .total_pixels (total_pixels)
    );

endmodule
